FILE: hdl/qrs_pkg.sv
// qrs_pkg: shared constants, case codes and the saturating root helper
// used by every module of the quadratic root solver; no dependencies
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int ROOT_FRAC_DEF  = 16;
  localparam int ROOT_W         = 32;
  localparam int CNT_W          = 2;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

  // which root formula applies to one word
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LINEAR,
    KIND_DOUBLE,
    KIND_TWO
  } kind_t;

  typedef struct packed {
    logic              sat;
    logic [ROOT_W-1:0] val;
  } root_t;

  // apply sign to a quotient magnitude, clip to signed 32 bits
  function automatic root_t sat_root(input logic [63:0] q, input logic neg);
    root_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (q > 64'h0000_0000_8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'h8000_0000;
      end else begin
        r.val = 32'h0 - q[ROOT_W-1:0];
      end
    end else begin
      if (q > 64'h0000_0000_7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'h7FFF_FFFF;
      end else begin
        r.val = q[ROOT_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/quadratic_root_solver_top.sv
// stages: products, discriminant, S = ceil(DW/2) square root stages, numerator
// selection, divider, output register; numerator width N = max(S, COEF_WIDTH) + 2
// throughput: one word per cycle, set by the one-bit-per-stage root and divider
// pipelines; a stalled output word freezes the whole pipeline
// reset: synchronous active-low rst_n clears every stage valid bit
// top level of the quadratic root solver; depends on qrs_pkg and submodules
module quadratic_root_solver_top import qrs_pkg::*; #(
  parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
  parameter int ROOT_FRAC_BITS = ROOT_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CNT_W-1:0]             out_root_count,
  output logic signed [ROOT_W-1:0]     out_first_root,
  output logic signed [ROOT_W-1:0]     out_second_root,
  output logic                         out_saturated
);

  localparam int CW   = COEF_WIDTH;
  // discriminant width: exact up to 30-bit coefficients, capped at 64 bits above
  localparam int DW   = (2 * CW + 3 > 64) ? 64 : 2 * CW + 3;
  localparam int SW   = (DW + 1) / 2;
  localparam int NSW  = ((SW > CW) ? SW : CW) + 2;
  localparam int DENW = CW + 1;
  localparam int SBW  = 2 + 3 * CW;

  // whole pipeline advances together unless the output word is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // products and discriminant
  logic                 f_valid;
  logic [DW-1:0]        f_d;
  kind_t                f_kind;
  logic signed [CW-1:0] f_a, f_b, f_c;

  qrs_front #(.CW(CW), .DW(DW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_a      (in_coef_a),
    .in_b      (in_coef_b),
    .in_c      (in_coef_c),
    .out_valid (f_valid),
    .out_d     (f_d),
    .out_kind  (f_kind),
    .out_a     (f_a),
    .out_b     (f_b),
    .out_c     (f_c)
  );

  // square root of the discriminant, coefficients ride along
  logic           s_valid;
  logic [SW-1:0]  s_root;
  logic [SBW-1:0] s_sb;

  qrs_sqrt #(.DW(DW), .SBW(SBW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_rad    (f_d),
    .in_sb     ({f_kind, f_a, f_b, f_c}),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_sb    (s_sb)
  );

  kind_t                s_kind;
  logic signed [CW-1:0] s_a, s_b, s_c;
  assign s_kind = kind_t'(s_sb[SBW-1 -: 2]);
  assign s_a    = s_sb[3*CW-1 -: CW];
  assign s_b    = s_sb[2*CW-1 -: CW];
  assign s_c    = s_sb[CW-1:0];

  // numerator and divisor selection stage
  logic signed [NSW-1:0] b_ext, c_ext, s_ext;
  logic signed [DENW:0]  a2_ext, bd_ext;
  logic signed [NSW-1:0] num1_nxt, num2_nxt;
  logic signed [DENW:0]  den_nxt;
  logic [CNT_W-1:0]      cnt_nxt;

  assign b_ext  = NSW'(s_b);
  assign c_ext  = NSW'(s_c);
  assign s_ext  = $signed(NSW'(s_root));
  assign a2_ext = (DENW+1)'(s_a) <<< 1;
  assign bd_ext = (DENW+1)'(s_b);

  always_comb begin
    num1_nxt = '0;
    num2_nxt = '0;
    den_nxt  = (DENW+1)'(1);
    cnt_nxt  = CNT_NONE;
    unique case (s_kind)
      KIND_NONE: begin
        cnt_nxt = CNT_NONE;
      end
      KIND_LINEAR: begin
        // single root -c/b
        num1_nxt = -c_ext;
        den_nxt  = bd_ext;
        cnt_nxt  = CNT_ONE;
      end
      KIND_DOUBLE: begin
        // repeated root -b/2a
        num1_nxt = -b_ext;
        den_nxt  = a2_ext;
        cnt_nxt  = CNT_ONE;
      end
      KIND_TWO: begin
        // minus-root branch first, plus-root branch second
        num1_nxt = -b_ext - s_ext;
        num2_nxt = -b_ext + s_ext;
        den_nxt  = a2_ext;
        cnt_nxt  = CNT_TWO;
      end
      default: begin
        cnt_nxt = CNT_NONE;
      end
    endcase
  end

  logic                  n_valid_r;
  logic signed [NSW-1:0] num1_r, num2_r;
  logic signed [DENW:0]  den_r;
  logic [CNT_W-1:0]      cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_valid_r <= 1'b0;
    end else if (adv) begin
      n_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1_r <= num1_nxt;
      num2_r <= num2_nxt;
      den_r  <= den_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // quotients, saturation and the output word register
  qrs_div #(.NSW(NSW), .DENW(DENW), .RF(ROOT_FRAC_BITS)) u_div (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (n_valid_r),
    .in_num1         (num1_r),
    .in_num2         (num2_r),
    .in_den          (den_r),
    .in_cnt          (cnt_r),
    .out_valid       (out_valid),
    .out_root_count  (out_root_count),
    .out_first_root  (out_first_root),
    .out_second_root (out_second_root),
    .out_saturated   (out_saturated)
  );

`ifndef SYNTH
  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count == CNT_NONE |->
      out_first_root == '0 && out_second_root == '0 && !out_saturated)
    else $error("word without roots carries root data");

  a_single_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count != CNT_TWO |-> out_second_root == '0)
    else $error("second root set on a word with fewer than two roots");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_root_count == CNT_NONE || out_root_count == CNT_ONE ||
      out_root_count == CNT_TWO)
    else $error("root count out of range");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output word");
`endif

endmodule

FILE: hdl/qrs_front.sv
// qrs_front: two register stages, coefficient products then discriminant
// and case selection; depends on qrs_pkg
module qrs_front import qrs_pkg::*; #(
  parameter int CW = COEF_WIDTH_DEF,
  parameter int DW = 2 * COEF_WIDTH_DEF + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_a,
  input  logic signed [CW-1:0] in_b,
  input  logic signed [CW-1:0] in_c,
  output logic                 out_valid,
  output logic        [DW-1:0] out_d,
  output kind_t                out_kind,
  output logic signed [CW-1:0] out_a,
  output logic signed [CW-1:0] out_b,
  output logic signed [CW-1:0] out_c
);

  logic                   v1_r;
  logic signed [CW-1:0]   a1_r, b1_r, c1_r;
  logic signed [2*CW-1:0] bb_r, ac_r;
  logic                   v2_r;
  logic        [DW-1:0]   d_r;
  kind_t                  kind_r;
  logic signed [CW-1:0]   a2_r, b2_r, c2_r;

  logic signed [DW-1:0]   d_nxt;
  kind_t                  kind_nxt;

  always_comb begin
    d_nxt = DW'(bb_r) - (DW'(ac_r) <<< 2);
    if (d_nxt[DW-1] || (a1_r == '0 && b1_r == '0)) begin
      kind_nxt = KIND_NONE;
    end else if (a1_r == '0) begin
      kind_nxt = KIND_LINEAR;
    end else if (d_nxt == '0) begin
      kind_nxt = KIND_DOUBLE;
    end else begin
      kind_nxt = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r   <= in_a;
      b1_r   <= in_b;
      c1_r   <= in_c;
      bb_r   <= in_b * in_b;
      ac_r   <= in_a * in_c;
      d_r    <= d_nxt;
      kind_r <= kind_nxt;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
      c2_r   <= c1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_d     = d_r;
  assign out_kind  = kind_r;
  assign out_a     = a2_r;
  assign out_b     = b2_r;
  assign out_c     = c2_r;

endmodule

FILE: hdl/qrs_sqrt.sv
// qrs_sqrt: integer square root, one result bit per register stage,
// side data carried alongside; depends on qrs_pkg
module qrs_sqrt import qrs_pkg::*; #(
  parameter int DW  = 2 * COEF_WIDTH_DEF + 3,
  parameter int SBW = 3 * COEF_WIDTH_DEF + 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [DW-1:0]             in_rad,
  input  logic [SBW-1:0]            in_sb,
  output logic                      out_valid,
  output logic [(DW+1)/2-1:0]       out_root,
  output logic [SBW-1:0]            out_sb
);

  localparam int SW = (DW + 1) / 2;
  localparam int RW = SW + 2;

  logic          valid_r [SW];
  logic [RW-1:0] rem_r   [SW];
  logic [SW-1:0] root_r  [SW];
  logic [2*SW-1:0] rad_r [SW];
  logic [SBW-1:0] sb_r   [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic            v_in;
    logic [RW-1:0]   rem_in;
    logic [SW-1:0]   root_in;
    logic [2*SW-1:0] rad_in;
    logic [SBW-1:0]  sb_in;
    logic [RW-1:0]   sh, trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = (2*SW)'(in_rad);
      assign sb_in   = in_sb;
    end else begin : g_next
      assign v_in    = valid_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    // bring down two radicand bits, try 4*root+1
    assign sh    = {rem_in[RW-3:0], rad_in[2*SW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? (sh - trial) : sh;
        root_r[k] <= {root_in[SW-2:0], ge};
        rad_r[k]  <= rad_in << 2;
        sb_r[k]   <= sb_in;
      end
    end
  end

  assign out_valid = valid_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_sb    = sb_r[SW-1];

endmodule

FILE: hdl/qrs_div.sv
// qrs_div: two-lane restoring divider over a shared divisor, one quotient
// bit per stage, then sign, saturation and output register; uses qrs_pkg
module qrs_div import qrs_pkg::*; #(
  parameter int NSW  = 20,
  parameter int DENW = COEF_WIDTH_DEF + 1,
  parameter int RF   = ROOT_FRAC_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic signed [NSW-1:0]  in_num1,
  input  logic signed [NSW-1:0]  in_num2,
  input  logic signed [DENW:0]   in_den,
  input  logic [CNT_W-1:0]       in_cnt,
  output logic                   out_valid,
  output logic [CNT_W-1:0]       out_root_count,
  output logic [ROOT_W-1:0]      out_first_root,
  output logic [ROOT_W-1:0]      out_second_root,
  output logic                   out_saturated
);

  localparam int DVW = NSW + RF;

  logic [NSW-1:0]  mag1, mag2;
  logic [DENW:0]   den_abs;
  logic            neg1, neg2;

  assign mag1    = in_num1[NSW-1] ? NSW'(-in_num1) : NSW'(in_num1);
  assign mag2    = in_num2[NSW-1] ? NSW'(-in_num2) : NSW'(in_num2);
  assign den_abs = in_den[DENW] ? (DENW+1)'(-in_den) : (DENW+1)'(in_den);
  assign neg1    = in_num1[NSW-1] != in_den[DENW];
  assign neg2    = in_num2[NSW-1] != in_den[DENW];

  logic            valid_r [DVW];
  logic [DENW-1:0] den_r   [DVW];
  logic [DVW-1:0]  n1_r    [DVW];
  logic [DVW-1:0]  n2_r    [DVW];
  logic [DENW-1:0] r1_r    [DVW];
  logic [DENW-1:0] r2_r    [DVW];
  logic [DVW-1:0]  q1_r    [DVW];
  logic [DVW-1:0]  q2_r    [DVW];
  logic            ng1_r   [DVW];
  logic            ng2_r   [DVW];
  logic [CNT_W-1:0] cnt_r  [DVW];

  for (genvar k = 0; k < DVW; k++) begin : g_stage
    logic            v_in, g1_in, g2_in;
    logic [DENW-1:0] den_in, r1_in, r2_in;
    logic [DVW-1:0]  n1_in, n2_in, q1_in, q2_in;
    logic [CNT_W-1:0] cnt_in;
    logic [DENW:0]   sh1, sh2;
    logic            ge1, ge2;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign den_in = den_abs[DENW-1:0];
      assign n1_in  = {mag1, RF'(0)};
      assign n2_in  = {mag2, RF'(0)};
      assign r1_in  = '0;
      assign r2_in  = '0;
      assign q1_in  = '0;
      assign q2_in  = '0;
      assign g1_in  = neg1;
      assign g2_in  = neg2;
      assign cnt_in = in_cnt;
    end else begin : g_next
      assign v_in   = valid_r[k-1];
      assign den_in = den_r[k-1];
      assign n1_in  = n1_r[k-1];
      assign n2_in  = n2_r[k-1];
      assign r1_in  = r1_r[k-1];
      assign r2_in  = r2_r[k-1];
      assign q1_in  = q1_r[k-1];
      assign q2_in  = q2_r[k-1];
      assign g1_in  = ng1_r[k-1];
      assign g2_in  = ng2_r[k-1];
      assign cnt_in = cnt_r[k-1];
    end

    assign sh1 = {r1_in, n1_in[DVW-1]};
    assign sh2 = {r2_in, n2_in[DVW-1]};
    assign ge1 = (sh1 >= {1'b0, den_in});
    assign ge2 = (sh2 >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[k] <= den_in;
        n1_r[k]  <= n1_in << 1;
        n2_r[k]  <= n2_in << 1;
        r1_r[k]  <= ge1 ? DENW'(sh1 - {1'b0, den_in}) : DENW'(sh1);
        r2_r[k]  <= ge2 ? DENW'(sh2 - {1'b0, den_in}) : DENW'(sh2);
        q1_r[k]  <= {q1_in[DVW-2:0], ge1};
        q2_r[k]  <= {q2_in[DVW-2:0], ge2};
        ng1_r[k] <= g1_in;
        ng2_r[k] <= g2_in;
        cnt_r[k] <= cnt_in;
      end
    end
  end

  root_t rt1, rt2;
  logic [CNT_W-1:0] cnt_l;

  assign rt1   = sat_root(64'(q1_r[DVW-1]), ng1_r[DVW-1]);
  assign rt2   = sat_root(64'(q2_r[DVW-1]), ng2_r[DVW-1]);
  assign cnt_l = cnt_r[DVW-1];

  logic              ov_r;
  logic [CNT_W-1:0]  ocnt_r;
  logic [ROOT_W-1:0] or1_r, or2_r;
  logic              osat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= valid_r[DVW-1];
    end
  end

  // absent roots read as zero and never flag saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      ocnt_r <= cnt_l;
      or1_r  <= (cnt_l != CNT_NONE) ? rt1.val : '0;
      or2_r  <= (cnt_l == CNT_TWO) ? rt2.val : '0;
      osat_r <= ((cnt_l != CNT_NONE) && rt1.sat) || ((cnt_l == CNT_TWO) && rt2.sat);
    end
  end

  assign out_valid       = ov_r;
  assign out_root_count  = ocnt_r;
  assign out_first_root  = or1_r;
  assign out_second_root = or2_r;
  assign out_saturated   = osat_r;

endmodule

FILE: verif/quadratic_root_solver_top_tb.sv
// testbench for quadratic_root_solver_top: directed table plus random coefficient words, each
// checked against its typed answer or a fixed-point root predictor; depends on qrs_pkg and the rtl
module quadratic_root_solver_top_tb import qrs_pkg::*;;

  localparam int CW        = 16;
  localparam int FRAC      = 16;
  localparam int N_RANDOM  = 480;
  localparam int DRAIN     = 90;    // final wait, longer than the pipeline latency
  localparam int IDLE_MAX  = 3000;  // cycles without any handshake before giving up
  localparam int LONG_HOLD = 300;   // receiver hold-off, well past the pipeline depth

  typedef struct {
    logic [CNT_W-1:0]  count;
    logic [ROOT_W-1:0] r1;
    logic [ROOT_W-1:0] r2;
    logic              sat;
  } roots_t;

  // one directed row; known marks rows whose answer is typed in
  typedef struct {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    bit                   known;
    roots_t               res;
  } coef_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_coef_a = '0;
  logic signed [CW-1:0] in_coef_b = '0;
  logic signed [CW-1:0] in_coef_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] out_root_count;
  logic signed [ROOT_W-1:0] out_first_root;
  logic signed [ROOT_W-1:0] out_second_root;
  logic out_saturated;

  roots_t pending_roots[$];
  int     errors = 0;
  int     words_in = 0;
  int     words_out = 0;
  int     idle_cycles = 0;
  int     stall_hits = 0;
  bit     hold_request = 1'b0;
  int     kind_seen[4] = '{0, 0, 0, 0};

  quadratic_root_solver_top #(.COEF_WIDTH(CW), .ROOT_FRAC_BITS(FRAC)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // floor of the square root of a nonnegative 64-bit value
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // num/den in Q16.16, truncated toward zero, clipped to signed 32 bits
  function automatic logic [ROOT_W-1:0] q16_quotient(longint num, longint den,
                                                     inout logic sat);
    longint unsigned nm, dm, q;
    logic neg;
    nm = (num < 0) ? -num : num;
    nm = nm << FRAC;
    dm = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    q = nm / dm;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
        sat = 1'b1;
      end
      return 32'h0 - q[31:0];
    end
    if (q > 64'h7FFF_FFFF) begin
      q = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    return q[31:0];
  endfunction

  // discriminant, then the root formula that applies
  function automatic roots_t solve_roots(logic signed [CW-1:0] ca,
                                         logic signed [CW-1:0] cb,
                                         logic signed [CW-1:0] cc);
    roots_t r;
    longint a, b, c, disc, s;
    a = ca;
    b = cb;
    c = cc;
    r = '{CNT_NONE, '0, '0, 1'b0};
    disc = b * b - 4 * a * c;
    if (disc < 0 || (a == 0 && b == 0)) begin
      r.count = CNT_NONE;
    end else if (a == 0) begin
      r.count = CNT_ONE;
      r.r1 = q16_quotient(-c, b, r.sat);
    end else if (disc == 0) begin
      r.count = CNT_ONE;
      r.r1 = q16_quotient(-b, 2 * a, r.sat);
    end else begin
      s = floor_sqrt(disc);
      r.count = CNT_TWO;
      r.r1 = q16_quotient(-b - s, 2 * a, r.sat);
      r.r2 = q16_quotient(-b + s, 2 * a, r.sat);
    end
    return r;
  endfunction

  // directed words: extremes of every field, each root formula, both clip limits reached
  coef_row_t directed[] = '{
    '{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh0000, 16'sh0000, -16'sh8000, 1'b1, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh0000, 16'sh0001, -16'sh8000, 1'b1, '{CNT_ONE, 32'h7FFF_FFFF, 32'h0, 1'b1}},
    '{16'sh0000, -16'sh0001, -16'sh8000, 1'b1, '{CNT_ONE, 32'h8000_0000, 32'h0, 1'b0}},
    '{16'sh0000, 16'sh0100, 16'sh0000, 1'b1, '{CNT_ONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh0001, 16'sh0000, 16'sh0001, 1'b1, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh0100, 16'sh0000, -16'sh0100, 1'b1,
      '{CNT_TWO, 32'hFFFF_0000, 32'h0001_0000, 1'b0}},
    '{16'sh0100, -16'sh0200, 16'sh0100, 1'b1, '{CNT_ONE, 32'h0001_0000, 32'h0, 1'b0}},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{-16'sh8000, -16'sh8000, 16'sh7FFF, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh7FFF, -16'sh8000, -16'sh8000, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh0001, -16'sh8000, 16'sh0000, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{-16'sh0001, 16'sh7FFF, -16'sh8000, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh0001, 16'sh0001, -16'sh8000, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{-16'sh0001, 16'sh0000, 16'sh7FFF, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh5555, -16'sh5556, 16'sh2AAA, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{-16'sh2AAB, 16'sh5555, 16'sh1234, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}},
    '{16'sh0003, 16'sh0007, -16'sh0005, 1'b0, '{CNT_NONE, 32'h0, 32'h0, 1'b0}}
  };

  // one coefficient word out of several shapes, most of them reaching real roots
  task automatic pick_coefs(output logic signed [CW-1:0] a, b, c);
    int k, m, shape;
    shape = $urandom_range(0, 9);
    a = CW'($urandom);
    b = CW'($urandom);
    c = CW'($urandom);
    case (shape) inside
      0, 1: ;                                // full-range noise
      2: a = '0;                             // linear
      3: begin                               // double root: b = -2mk, c = mk^2
        m = $urandom_range(1, 40) * (($urandom & 1) ? 1 : -1);
        k = $signed($urandom_range(0, 28)) - 14;
        a = CW'(m);
        b = CW'(-2 * m * k);
        c = CW'(m * k * k);
      end
      4, 5: begin                            // small a, c of opposite sign: two roots
        a = CW'($signed($urandom_range(1, 1023)) * (($urandom & 1) ? 1 : -1));
        c = (a > 0) ? CW'(-$signed($urandom_range(0, 32767)))
                    : CW'($urandom_range(0, 32767));
      end
      6: begin                               // tiny a, one root near the clip limits
        a = ($urandom & 1) ? 16'sh0001 : -16'sh0001;
        b = ($urandom & 1) ? 16'sh7FFF : -16'sh8000;
      end
      7: begin                               // all small
        a = CW'($signed($urandom_range(0, 64)) - 32);
        b = CW'($signed($urandom_range(0, 64)) - 32);
        c = CW'($signed($urandom_range(0, 64)) - 32);
      end
      default: begin                         // linear with tiny b, mostly large roots
        a = '0;
        b = CW'($signed($urandom_range(0, 6)) - 3);
      end
    endcase
  endtask

  // random gap before the next word: mostly none, sometimes short, rarely long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one word and hold it until it is taken
  task automatic send_word(logic signed [CW-1:0] a, b, c, bit known, roots_t typed);
    roots_t want;
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_coef_a = a;
    in_coef_b = b;
    in_coef_c = c;
    do begin
      @(posedge clk);
      if (in_stall) stall_hits++;
    end while (in_stall);
    want = known ? typed : solve_roots(a, b, c);
    pending_roots.push_back(want);
    kind_seen[want.count]++;
    if (want.sat) kind_seen[3]++;
    words_in++;
    @(negedge clk);
  endtask

  // sender: reset, directed table, then random words with the two pressure points
  initial begin
    logic signed [CW-1:0] a, b, c;
    roots_t none;
    none = '{CNT_NONE, '0, '0, 1'b0};
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    foreach (directed[i])
      send_word(directed[i].a, directed[i].b, directed[i].c, directed[i].known,
                directed[i].res);
    for (int n = 0; n < N_RANDOM; n++) begin
      // ask the receiver for a long hold-off, keep offering so the pipe backs up
      if (n == 150) hold_request = 1'b1;
      // pause until the pipe has drained completely
      if (n == 350) begin
        in_valid = 1'b0;
        wait (pending_roots.size() == 0);
        @(negedge clk);
      end
      pick_coefs(a, b, c);
      send_word(a, b, c, 1'b0, none);
    end
    in_valid = 1'b0;
    wait (pending_roots.size() == 0);
    repeat (DRAIN) @(posedge clk);
    $display("%0d words sent, %0d results checked, input stalled on %0d cycles",
             words_in, words_out, stall_hits);
    $display("no-root %0d, one-root %0d, two-root %0d, clipped %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    int p;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      p = $urandom_range(0, 99);
      if (p < 55) begin
        out_stall = 1'b0;
      end else if (p < 95) begin
        out_stall = 1'b1;
      end else begin
        // long stall, counted here at negedges
        out_stall = 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  // result checker: compare every accepted word with the oldest expectation
  always @(posedge clk) begin
    roots_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (pending_roots.size() == 0) begin
        $display("%0t: result with nothing expected: count %0d roots %h %h sat %b",
                 $time, out_root_count, out_first_root, out_second_root, out_saturated);
        errors++;
      end else begin
        want = pending_roots.pop_front();
        if (out_root_count !== want.count) begin
          $display("%0t: root_count expected %0d got %0d", $time, want.count,
                   out_root_count);
          errors++;
        end
        if (out_first_root !== want.r1) begin
          $display("%0t: first_root expected %h got %h", $time, want.r1, out_first_root);
          errors++;
        end
        if (out_second_root !== want.r2) begin
          $display("%0t: second_root expected %h got %h", $time, want.r2,
                   out_second_root);
          errors++;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated expected %b got %b", $time, want.sat, out_saturated);
          errors++;
        end
      end
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("timeout with %0d results outstanding", pending_roots.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
hdl/qrs_pkg.sv
hdl/qrs_front.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver_top.sv
verif/quadratic_root_solver_top_tb.sv
